FILE: rtl/fsbm_pkg.sv
// ----------------------------------------------------------------------------
// fsbm_pkg
// Shared sizes, codes, mask groups and helpers of the flag set best-match
// search unit.
// ----------------------------------------------------------------------------
package fsbm_pkg;

    localparam int ENTRIES   = 64;
    localparam int FLAG_BITS = 28;

    localparam int FLAG_W   = 28;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int SCORE_W  = 5;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 * ENTRIES;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [31:0] GROUP_LIGHT_RX  = 32'h0000_001C;
    localparam logic [31:0] GROUP_SHADOW_RX = 32'h0000_00E0;
    localparam logic [31:0] GROUP_SHADOW_TX = 32'h0000_0700;
    localparam logic [31:0] GROUP_BONES     = 32'h001F_0000;
    localparam logic [31:0] GROUP_ALL       = GROUP_LIGHT_RX | GROUP_SHADOW_RX |
                                              GROUP_SHADOW_TX | GROUP_BONES;
    localparam logic [31:0] GROUP_MASKS [4] = '{GROUP_LIGHT_RX, GROUP_SHADOW_RX,
                                                GROUP_SHADOW_TX, GROUP_BONES};

    localparam logic [63:0] BIT_MASK64 = (64'd1 << FLAG_BITS) - 64'd1;
    localparam logic [31:0] SCORE_MASK = BIT_MASK64[31:0] & ~GROUP_ALL;

    function automatic int count_bits(input logic [31:0] v);
        int n;
        n = 0;
        for (int b = 0; b < 32; b++) begin
            n = n + int'(v[b]);
        end
        return n;
    endfunction

    localparam logic [SCORE_W-1:0] EXACT_SCORE = SCORE_W'(count_bits(SCORE_MASK) + 4);

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_EXACT = 3'd3,
        ST_BEST  = 3'd4,
        ST_NONE  = 3'd5
    } t_status;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               better;
    } t_score_res;

    function automatic logic [INDEX_W-1:0] to_entry_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, idx};
        return wide[INDEX_W-1:0];
    endfunction

endpackage

FILE: rtl/fsbm_in_if.sv
// ----------------------------------------------------------------------------
// fsbm_in_if
// Request channel: load or query transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsbm_in_if
    import fsbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic              shader_type;
    logic [FLAG_W-1:0] flag_word;

    modport source (output valid, output mode, output shader_type, output flag_word,
                    input ready);
    modport sink   (input valid, input mode, input shader_type, input flag_word,
                    output ready);
endinterface

FILE: rtl/fsbm_out_if.sv
// ----------------------------------------------------------------------------
// fsbm_out_if
// Result channel: one result transaction per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsbm_out_if
    import fsbm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FLAG_W-1:0]   matched_flags;
    logic [INDEX_W-1:0]  entry_index;
    logic [SCORE_W-1:0]  match_score;

    modport source (output valid, output status, output matched_flags,
                    output entry_index, output match_score, input ready);
    modport sink   (input valid, input status, input matched_flags,
                    input entry_index, input match_score, output ready);
endinterface

FILE: rtl/fsbm_ram.sv
// ----------------------------------------------------------------------------
// fsbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsbm_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/fsbm_score_unit.sv
// ----------------------------------------------------------------------------
// fsbm_score_unit
// Shared scoring unit: scores one stored entry against the request word and
// compares the score with the best one so far.
// ----------------------------------------------------------------------------
module fsbm_score_unit
    import fsbm_pkg::*;
(
    input  logic [FLAG_W-1:0]  i_query,
    input  logic [FLAG_W-1:0]  i_entry,
    input  logic [SCORE_W-1:0] i_best_score,
    input  logic               i_have_best,
    output t_score_res         o_res
);

    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        same;
    logic [5:0]         n;
    logic [SCORE_W-1:0] score;

    always_comb begin
        x    = {{(32 - FLAG_W){1'b0}}, i_query};
        y    = {{(32 - FLAG_W){1'b0}}, i_entry};
        same = ~(x ^ y) & SCORE_MASK;
        n    = 6'd0;
        for (int b = 0; b < 32; b++) begin
            n = n + 6'(same[b]);
        end
        for (int g = 0; g < 4; g++) begin
            n = n + 6'(((x | y) & GROUP_MASKS[g]) == 32'd0);
            n = n + 6'((x & y & GROUP_MASKS[g]) != 32'd0);
        end
        score        = n[SCORE_W-1:0];
        o_res.score  = score;
        o_res.better = !i_have_best || (score > i_best_score);
    end

endmodule

FILE: rtl/flag_set_best_match_search_unit.sv
// ----------------------------------------------------------------------------
// flag_set_best_match_search_unit
// Two sorted tables of feature-flag words; loads insert in order, queries
// return the exact or best scoring entry.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// i_in     in   valid/ready   mode, shader_type, flag_word
// o_out    out  valid/ready   status, matched_flags, entry_index, match_score
//
// Query: the scan reads one entry per cycle from the table RAM through the
// shared score unit. Load: the scan finds the insert place, the entries at
// and above it are moved up one place, and then the new word is written.
// Reset clears both entry counts; the table RAM holds no reset value.
// i_in.ready is high only when no transaction is in work; a result waits in
// the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module flag_set_best_match_search_unit
    import fsbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsbm_in_if.sink     i_in,
    fsbm_out_if.source  o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state,   n_state;
    logic                r_mode,    n_mode;
    logic                r_type,    n_type;
    logic [FLAG_W-1:0]   r_word,    n_word;
    logic [CNT_W-1:0]    r_cnt,     n_cnt;
    logic [CNT_W-1:0]    r_idx,     n_idx;
    logic                r_pend,    n_pend;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]    r_pos,     n_pos;
    logic [IDX_W-1:0]    r_j,       n_j;
    logic [CNT_W-1:0]    r_left,    n_left;
    logic                r_wpend,   n_wpend;
    logic [IDX_W-1:0]    r_wj,      n_wj;
    logic                r_have,    n_have;
    logic [SCORE_W-1:0]  r_bscore,  n_bscore;
    logic [IDX_W-1:0]    r_bidx,    n_bidx;
    logic [FLAG_W-1:0]   r_bflags,  n_bflags;
    logic [CNT_W-1:0]    r_count0,  n_count0;
    logic [CNT_W-1:0]    r_count1,  n_count1;
    t_status             r_rstatus, n_rstatus;
    logic [FLAG_W-1:0]   r_rflags,  n_rflags;
    logic [IDX_W-1:0]    r_ridx,    n_ridx;
    logic [SCORE_W-1:0]  r_rscore,  n_rscore;
    logic                r_ovalid,  n_ovalid;
    t_status             r_ostatus, n_ostatus;
    logic [FLAG_W-1:0]   r_oflags,  n_oflags;
    logic [INDEX_W-1:0]  r_oidx,    n_oidx;
    logic [SCORE_W-1:0]  r_oscore,  n_oscore;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [FLAG_W-1:0]   ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [FLAG_W-1:0]   ram_rd_data;
    t_score_res          sres;
    logic                stop;
    logic [CNT_W-1:0]    in_cnt;
    logic [CNT_W-1:0]    place_left;
    logic [IDX_W-1:0]    place_pos;
    logic                place;

    fsbm_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    fsbm_score_unit u_score (
        .i_query      (r_word),
        .i_entry      (ram_rd_data),
        .i_best_score (r_bscore),
        .i_have_best  (r_have),
        .o_res        (sres)
    );

    assign in_cnt = i_in.shader_type ? r_count1 : r_count0;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_type    = r_type;
        n_word    = r_word;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_cmp_idx = r_cmp_idx;
        n_pos     = r_pos;
        n_j       = r_j;
        n_left    = r_left;
        n_wpend   = r_wpend;
        n_wj      = r_wj;
        n_have    = r_have;
        n_bscore  = r_bscore;
        n_bidx    = r_bidx;
        n_bflags  = r_bflags;
        n_count0  = r_count0;
        n_count1  = r_count1;
        n_rstatus = r_rstatus;
        n_rflags  = r_rflags;
        n_ridx    = r_ridx;
        n_rscore  = r_rscore;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_oflags  = r_oflags;
        n_oidx    = r_oidx;
        n_oscore  = r_oscore;

        ram_wr_en   = 1'b0;
        ram_wr_addr = {r_type, r_pos};
        ram_wr_data = r_word;
        ram_rd_addr = {r_type, r_idx[IDX_W-1:0]};
        stop        = 1'b0;
        place       = 1'b0;
        place_pos   = r_cmp_idx;
        place_left  = '0;
        i_in.ready  = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_mode = i_in.mode;
                    n_type = i_in.shader_type;
                    n_word = i_in.flag_word;
                    n_cnt  = in_cnt;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_have = 1'b0;
                    if (i_in.mode == MODE_QUERY && in_cnt == '0) begin
                        n_rstatus = ST_NONE;
                        n_rflags  = '0;
                        n_ridx    = '0;
                        n_rscore  = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_pend) begin
                    if (ram_rd_data == r_word) begin
                        stop      = 1'b1;
                        n_rstatus = (r_mode == MODE_LOAD) ? ST_DUP : ST_EXACT;
                        n_rscore  = (r_mode == MODE_LOAD) ? '0 : EXACT_SCORE;
                        n_rflags  = r_word;
                        n_ridx    = r_cmp_idx;
                        n_state   = S_DONE;
                    end else if (r_mode == MODE_LOAD && ram_rd_data > r_word) begin
                        stop       = 1'b1;
                        place      = 1'b1;
                        place_pos  = r_cmp_idx;
                        place_left = r_cnt - CNT_W'(r_cmp_idx);
                    end else if (r_mode == MODE_QUERY && sres.better) begin
                        n_have   = 1'b1;
                        n_bscore = sres.score;
                        n_bidx   = r_cmp_idx;
                        n_bflags = ram_rd_data;
                    end
                end
                if (!stop) begin
                    if (r_idx < r_cnt) begin
                        ram_rd_addr = {r_type, r_idx[IDX_W-1:0]};
                        n_idx       = r_idx + CNT_W'(1);
                        n_pend      = 1'b1;
                        n_cmp_idx   = r_idx[IDX_W-1:0];
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            if (r_mode == MODE_LOAD) begin
                                place      = 1'b1;
                                place_pos  = r_cnt[IDX_W-1:0];
                                place_left = '0;
                            end else begin
                                n_rstatus = ST_BEST;
                                n_rflags  = r_bflags;
                                n_ridx    = r_bidx;
                                n_rscore  = r_bscore;
                                n_state   = S_DONE;
                            end
                        end
                    end
                end
                if (place) begin
                    if (r_cnt >= CNT_W'(ENTRIES)) begin
                        n_rstatus = ST_FULL;
                        n_rflags  = '0;
                        n_ridx    = '0;
                        n_rscore  = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_pos   = place_pos;
                        n_left  = place_left;
                        n_j     = IDX_W'(r_cnt - CNT_W'(1));
                        n_wpend = 1'b0;
                        n_state = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                if (r_wpend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = {r_type, IDX_W'(r_wj + IDX_W'(1))};
                    ram_wr_data = ram_rd_data;
                end
                if (r_left != '0) begin
                    ram_rd_addr = {r_type, r_j};
                    n_wj        = r_j;
                    n_wpend     = 1'b1;
                    n_j         = r_j - IDX_W'(1);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = {r_type, r_pos};
                        ram_wr_data = r_word;
                        if (r_type) begin
                            n_count1 = r_cnt + CNT_W'(1);
                        end else begin
                            n_count0 = r_cnt + CNT_W'(1);
                        end
                        n_rstatus = ST_ADDED;
                        n_rflags  = r_word;
                        n_ridx    = r_pos;
                        n_rscore  = '0;
                        n_state   = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rstatus;
                    n_oflags  = r_rflags;
                    n_oidx    = to_entry_index(r_ridx);
                    n_oscore  = r_rscore;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count0 <= '0;
            r_count1 <= '0;
            r_pend   <= 1'b0;
            r_wpend  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_count0 <= n_count0;
            r_count1 <= n_count1;
            r_pend   <= n_pend;
            r_wpend  <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_type    <= n_type;
        r_word    <= n_word;
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_pos     <= n_pos;
        r_j       <= n_j;
        r_left    <= n_left;
        r_wj      <= n_wj;
        r_have    <= n_have;
        r_bscore  <= n_bscore;
        r_bidx    <= n_bidx;
        r_bflags  <= n_bflags;
        r_rstatus <= n_rstatus;
        r_rflags  <= n_rflags;
        r_ridx    <= n_ridx;
        r_rscore  <= n_rscore;
        r_ostatus <= n_ostatus;
        r_oflags  <= n_oflags;
        r_oidx    <= n_oidx;
        r_oscore  <= n_oscore;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_ostatus;
    assign o_out.matched_flags = r_oflags;
    assign o_out.entry_index   = r_oidx;
    assign o_out.match_score   = r_oscore;

endmodule

FILE: rtl/fsbm_checker.sv
// ----------------------------------------------------------------------------
// fsbm_checker
// Port-level checks of the flag set best-match search unit, bound to the top.
// ----------------------------------------------------------------------------
module fsbm_checker
    import fsbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [FLAG_W-1:0]   i_flags,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [SCORE_W-1:0]  i_score
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while a transaction is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable({i_status, i_flags, i_index, i_score})))
        else $error("stalled result transaction changed");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_NONE || i_status == ST_FULL)) |->
        (i_flags == '0 && i_index == '0 && i_score == '0))
        else $error("no-entry result carries nonzero fields");

    a_exact_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_EXACT) |-> (i_score == EXACT_SCORE))
        else $error("exact match with wrong score");

    a_load_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_ADDED || i_status == ST_DUP)) |->
        (i_score == '0))
        else $error("load result with nonzero score");

endmodule

bind flag_set_best_match_search_unit fsbm_checker u_fsbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_flags     (o_out.matched_flags),
    .i_index     (o_out.entry_index),
    .i_score     (o_out.match_score)
);
